/* hdl/kipt_pkg.sv */
package kipt_pkg;

   // Field widths of the command word that runs from the front part to the back part.
   // They cover a table of up to 256 slots; the request and response slot fields limit the block to 32.
   localparam int SLOT_FIELD_W = 8;
   localparam int USED_FIELD_W = 9;

   // Depth of the command queue between the two parts.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [30:0] NSEC_PER_SEC = 31'd1000000000;
   localparam logic [29:0] NSEC_MAX     = 30'd999999999;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_START = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_MISS   = 2'd2,
      ST_UNUSED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_CLEAR,
      CMD_FULL,
      CMD_MISS,
      CMD_UNUSED,
      CMD_START_NEW,
      CMD_START_HIT,
      CMD_STOP,
      CMD_READ
   } cmd_op_type;

   typedef enum logic {
      F_IDLE,
      F_CLASS
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_FETCH,
      B_ACC,
      B_DONE
   } back_state_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] key;
      logic [31:0] now_sec;
      logic [29:0] now_nsec;
      logic [4:0]  slot;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  hit_slot;
      logic [31:0] entry_key;
      logic [31:0] run_count;
      logic [31:0] total_sec;
      logic [29:0] total_nsec;
      logic [5:0]  used_entries;
   } rsp_type;

   typedef struct packed {
      cmd_op_type                op;
      logic [SLOT_FIELD_W-1:0]   slot;
      logic [USED_FIELD_W-1:0]   used;
      logic [31:0]               key;
      logic [31:0]               now_sec;
      logic [29:0]               now_nsec;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_flags_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] count;
      logic [31:0] total_sec;
      logic [29:0] total_nsec;
      logic [31:0] start_sec;
      logic [29:0] start_nsec;
   } entry_type;

endpackage

/* hdl/kipt_ram.sv */
module kipt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/kipt_front.sv */
module kipt_front #(
   parameter int ENTRY_COUNT = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  kipt_pkg::req_type         req_payload,
   input  kipt_pkg::queue_flags_type q_flags,
   output logic                      q_push,
   output kipt_pkg::cmd_type         q_cmd
);

   localparam int IDX_W  = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int FILL_W = $clog2(ENTRY_COUNT + 1);

   kipt_pkg::front_state_type state_ff, state_in;
   kipt_pkg::req_type         item_ff, item_in;
   logic [ENTRY_COUNT-1:0]    match_ff, match_in;
   logic [31:0]               key_ff [ENTRY_COUNT];
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic                      key_we;
   logic                      accept;
   logic                      hit;
   logic [IDX_W-1:0]          hit_idx;
   logic [29:0]               nsec_clamped;

   assign accept    = req_valid && (state_ff == kipt_pkg::F_IDLE);
   assign req_stall = (state_ff != kipt_pkg::F_IDLE);

   assign nsec_clamped = (req_payload.now_nsec > kipt_pkg::NSEC_MAX) ?
                         kipt_pkg::NSEC_MAX : req_payload.now_nsec;

   always_comb begin
      item_in          = req_payload;
      item_in.now_nsec = nsec_clamped;
   end

   // One comparator per slot; slots at or above the fill level never match.
   always_comb begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         match_in[i] = (key_ff[i] == req_payload.key) && (FILL_W'(i) < fill_ff);
      end
   end

   // Lowest matching slot wins.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kipt_pkg::F_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff  <= item_in;
         match_ff <= match_in;
      end
      if (key_we) begin
         key_ff[fill_ff[IDX_W-1:0]] <= item_ff.key;
      end
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      q_push         = 1'b0;
      key_we         = 1'b0;
      q_cmd          = '0;
      q_cmd.op       = kipt_pkg::CMD_CLEAR;
      q_cmd.key      = item_ff.key;
      q_cmd.now_sec  = item_ff.now_sec;
      q_cmd.now_nsec = item_ff.now_nsec;
      unique case (state_ff)
         kipt_pkg::F_IDLE: begin
            if (accept) begin
               state_in = kipt_pkg::F_CLASS;
            end
         end
         kipt_pkg::F_CLASS: begin
            if (!q_flags.full) begin
               q_push   = 1'b1;
               state_in = kipt_pkg::F_IDLE;
               unique case (item_ff.action)
                  kipt_pkg::ACT_CLEAR: begin
                     q_cmd.op = kipt_pkg::CMD_CLEAR;
                     fill_in  = '0;
                  end
                  kipt_pkg::ACT_START: begin
                     if (hit) begin
                        q_cmd.op   = kipt_pkg::CMD_START_HIT;
                        q_cmd.slot = kipt_pkg::SLOT_FIELD_W'(hit_idx);
                     end else if (fill_ff == FILL_W'(ENTRY_COUNT)) begin
                        q_cmd.op = kipt_pkg::CMD_FULL;
                     end else begin
                        q_cmd.op   = kipt_pkg::CMD_START_NEW;
                        q_cmd.slot = kipt_pkg::SLOT_FIELD_W'(fill_ff);
                        key_we     = 1'b1;
                        fill_in    = fill_ff + FILL_W'(1);
                     end
                  end
                  kipt_pkg::ACT_STOP: begin
                     if (hit) begin
                        q_cmd.op   = kipt_pkg::CMD_STOP;
                        q_cmd.slot = kipt_pkg::SLOT_FIELD_W'(hit_idx);
                     end else begin
                        q_cmd.op = kipt_pkg::CMD_MISS;
                     end
                  end
                  kipt_pkg::ACT_READ: begin
                     q_cmd.slot = kipt_pkg::SLOT_FIELD_W'(item_ff.slot);
                     if (kipt_pkg::USED_FIELD_W'(item_ff.slot) <
                         kipt_pkg::USED_FIELD_W'(fill_ff)) begin
                        q_cmd.op = kipt_pkg::CMD_READ;
                     end else begin
                        q_cmd.op = kipt_pkg::CMD_UNUSED;
                     end
                  end
               endcase
               q_cmd.used = kipt_pkg::USED_FIELD_W'(fill_in);
            end
         end
      endcase
   end

endmodule

/* hdl/kipt_queue.sv */
module kipt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  kipt_pkg::cmd_type         push_cmd,
   input  logic                      pop,
   output kipt_pkg::cmd_type         head,
   output kipt_pkg::queue_flags_type flags
);

   localparam int PTR_W = (kipt_pkg::QUEUE_DEPTH > 1) ? $clog2(kipt_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(kipt_pkg::QUEUE_DEPTH + 1);

   kipt_pkg::cmd_type slot_ff [kipt_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign flags.full  = (count_ff == CNT_W'(kipt_pkg::QUEUE_DEPTH));
   assign flags.empty = (count_ff == '0);
   assign do_push     = push && !flags.full;
   assign do_pop      = pop && !flags.empty;
   assign head        = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(kipt_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(kipt_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/kipt_back.sv */
module kipt_back #(
   parameter int ENTRY_COUNT = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kipt_pkg::queue_flags_type q_flags,
   input  kipt_pkg::cmd_type         q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output kipt_pkg::rsp_type         rsp_payload
);

   localparam int IDX_W   = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int ENTRY_W = $bits(kipt_pkg::entry_type);

   kipt_pkg::back_state_type state_ff, state_in;
   kipt_pkg::cmd_type        cmd_ff, cmd_in;
   kipt_pkg::entry_type      word_ff, rd_word, wr_word;
   kipt_pkg::rsp_type        rsp_ff, rsp_in;
   logic                     rsp_valid_ff;
   logic [30:0]              nsub_ff;
   logic [31:0]              ssub_ff;
   logic [30:0]              tn_ff;
   logic [31:0]              ts_ff;
   logic [31:0]              cnt_ff;
   logic                     ram_rd_en, ram_wr_en;
   logic [ENTRY_W-1:0]       ram_rd_data;
   logic                     need_read;
   logic                     out_free;
   logic                     load_rsp;
   logic                     carry;
   logic [30:0]              tn_norm;
   logic [31:0]              ts_norm;

   kipt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRY_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cmd_ff.slot[IDX_W-1:0]),
      .wr_data (wr_word),
      .rd_en   (ram_rd_en),
      .rd_addr (q_head.slot[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rd_word  = kipt_pkg::entry_type'(ram_rd_data);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Final carry of the nanosecond total into the seconds.
   assign carry   = (tn_ff >= kipt_pkg::NSEC_PER_SEC);
   assign tn_norm = carry ? (tn_ff - kipt_pkg::NSEC_PER_SEC) : tn_ff;
   assign ts_norm = ts_ff + 32'(carry);

   always_comb begin
      unique case (q_head.op) inside
         kipt_pkg::CMD_START_HIT, kipt_pkg::CMD_STOP, kipt_pkg::CMD_READ: need_read = 1'b1;
         default: need_read = 1'b0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      q_pop     = 1'b0;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      load_rsp  = 1'b0;
      wr_word   = word_ff;
      rsp_in              = '0;
      rsp_in.status       = kipt_pkg::ST_OK;
      rsp_in.hit_slot     = cmd_ff.slot[4:0];
      rsp_in.used_entries = cmd_ff.used[5:0];
      unique case (state_ff)
         kipt_pkg::B_IDLE: begin
            if (!q_flags.empty) begin
               q_pop     = 1'b1;
               cmd_in    = q_head;
               ram_rd_en = need_read;
               state_in  = need_read ? kipt_pkg::B_FETCH : kipt_pkg::B_DONE;
            end
         end
         kipt_pkg::B_FETCH: begin
            state_in = (cmd_ff.op == kipt_pkg::CMD_STOP) ? kipt_pkg::B_ACC : kipt_pkg::B_DONE;
         end
         kipt_pkg::B_ACC: begin
            state_in = kipt_pkg::B_DONE;
         end
         kipt_pkg::B_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = kipt_pkg::B_IDLE;
               unique case (cmd_ff.op)
                  kipt_pkg::CMD_CLEAR: begin
                     rsp_in.status = kipt_pkg::ST_OK;
                  end
                  kipt_pkg::CMD_FULL: begin
                     rsp_in.status = kipt_pkg::ST_FULL;
                  end
                  kipt_pkg::CMD_MISS: begin
                     rsp_in.status = kipt_pkg::ST_MISS;
                  end
                  kipt_pkg::CMD_UNUSED: begin
                     rsp_in.status = kipt_pkg::ST_UNUSED;
                  end
                  kipt_pkg::CMD_START_NEW: begin
                     ram_wr_en          = 1'b1;
                     wr_word            = '0;
                     wr_word.key        = cmd_ff.key;
                     wr_word.start_sec  = cmd_ff.now_sec;
                     wr_word.start_nsec = cmd_ff.now_nsec;
                     rsp_in.entry_key   = cmd_ff.key;
                  end
                  kipt_pkg::CMD_START_HIT: begin
                     ram_wr_en          = 1'b1;
                     wr_word.start_sec  = cmd_ff.now_sec;
                     wr_word.start_nsec = cmd_ff.now_nsec;
                     rsp_in.entry_key   = word_ff.key;
                     rsp_in.run_count   = word_ff.count;
                     rsp_in.total_sec   = word_ff.total_sec;
                     rsp_in.total_nsec  = word_ff.total_nsec;
                  end
                  kipt_pkg::CMD_STOP: begin
                     ram_wr_en          = 1'b1;
                     wr_word.count      = cnt_ff;
                     wr_word.total_sec  = ts_norm;
                     wr_word.total_nsec = tn_norm[29:0];
                     rsp_in.entry_key   = word_ff.key;
                     rsp_in.run_count   = cnt_ff;
                     rsp_in.total_sec   = ts_norm;
                     rsp_in.total_nsec  = tn_norm[29:0];
                  end
                  kipt_pkg::CMD_READ: begin
                     rsp_in.entry_key   = word_ff.key;
                     rsp_in.run_count   = word_ff.count;
                     rsp_in.total_sec   = word_ff.total_sec;
                     rsp_in.total_nsec  = word_ff.total_nsec;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kipt_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
      if (state_ff == kipt_pkg::B_FETCH) begin
         word_ff <= rd_word;
         // Signed difference; bit 30 set means a borrow from the seconds.
         nsub_ff <= {1'b0, cmd_ff.now_nsec} - {1'b0, rd_word.start_nsec};
         ssub_ff <= cmd_ff.now_sec - rd_word.start_sec;
      end
      if (state_ff == kipt_pkg::B_ACC) begin
         tn_ff  <= {1'b0, word_ff.total_nsec} + nsub_ff +
                   (nsub_ff[30] ? kipt_pkg::NSEC_PER_SEC : 31'd0);
         ts_ff  <= word_ff.total_sec + ssub_ff + {32{nsub_ff[30]}};
         cnt_ff <= (&word_ff.count) ? word_ff.count : word_ff.count + 32'd1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* hdl/keyed_interval_profiler_table_top.sv */
// Keyed interval profiler table. Each request beat carries an action (clear, start, stop or
// read), a 32-bit key that names a profiled region, the current time as seconds and
// nanoseconds, and a slot number for reads; every request beat produces exactly one response
// beat, in order. A start on an unknown key allocates the next free slot with zeroed totals
// and records the start time, a stop on a known key adds the elapsed time (with carry and
// borrow at one second) to the slot's totals and bumps its saturating run count, a clear
// empties the table at once, and a read returns one slot. Nanosecond inputs above 999999999
// are taken as 999999999. The design has two halves joined by a two-entry command queue: the
// front half registers a request beat with the result of comparing its key against every
// stored key in parallel, then classifies it and pushes the command once the queue has room,
// taking no new beat meanwhile; the back half owns the slot memory (one read port, one write
// port) and takes clear, table-full, key-not-found, unused-slot and first-start commands
// straight to its done state, a start of a known key or a read through a fetch of the slot,
// and a stop through a fetch, an accumulate step and a write back; a new command is popped
// only after the last has finished. Slots beyond the fill level are never read, so the memory
// needs no clearing after reset and a request can be taken in the first cycle after reset.
module keyed_interval_profiler_table_top #(
   parameter int ENTRY_COUNT = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kipt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kipt_pkg::rsp_type rsp_payload
);

   // Commands travel from the classifier to the executor through this queue, so a stalled
   // response does not hold up the classification of the beats behind it until the queue is full.
   kipt_pkg::cmd_type         push_cmd;
   kipt_pkg::cmd_type         head_cmd;
   kipt_pkg::queue_flags_type queue_flags;
   logic                      push;
   logic                      pop;

   // The front half owns the key store and the fill level, so the next beat always sees the
   // allocation made by the one before it, however far the back half lags.
   kipt_front #(
      .ENTRY_COUNT (ENTRY_COUNT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_flags     (queue_flags),
      .q_push      (push),
      .q_cmd       (push_cmd)
   );

   kipt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head_cmd),
      .flags    (queue_flags)
   );

   // The back half holds the counts, totals and start times, and the output register that
   // lets the response side stall without stopping the front half until the queue fills.
   kipt_back #(
      .ENTRY_COUNT (ENTRY_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_flags     (queue_flags),
      .q_head      (head_cmd),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hdl/kipt_checker.sv */
module kipt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input kipt_pkg::rsp_type rsp_payload
);

   logic       req_beat;
   logic       rsp_beat;
   logic [3:0] pending_ff;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   // Request beats taken whose response beat has not yet been delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 4'(req_beat) - 4'(rsp_beat);
      end
   end

   // The classifier stalls the request side after every beat it takes, while it classifies that beat.
   a_stall_after_beat : assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("request side not stalled in the cycle after a beat");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response beat changed or vanished");

   a_rsp_has_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 4'd0))
      else $error("response beat without an outstanding request beat");

   // Classifier, two queue entries, executor and output register hold at most five beats.
   a_pending_bound : assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'd5)
      else $error("more request beats outstanding than the design can hold");

endmodule

bind keyed_interval_profiler_table_top kipt_checker u_kipt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
